@@ design/frt_pkg.sv @@
package frt_pkg;

  // Frame geometry and buffer sizes
  localparam int unsigned SegmentBytes   = 256;
  localparam int unsigned MaxSegments    = 8;
  localparam int unsigned BufferBytes    = 2048;
  localparam int unsigned MaxHeaderBytes = 6;
  localparam int unsigned MacBytes       = 16;
  localparam int unsigned MinPacketBytes = 4;
  localparam int unsigned SegShift       = $clog2(SegmentBytes);

  // Field widths
  localparam int unsigned IdxW   = 8;
  localparam int unsigned TotW   = 16;
  localparam int unsigned KeyW   = 8;
  localparam int unsigned StatW  = 3;
  localparam int unsigned OffW   = 12;
  localparam int unsigned LenW   = 9;
  localparam int unsigned CntW   = 32;
  localparam int unsigned RoomW  = 3;
  localparam int unsigned PaddrW = 3;

  localparam logic [IdxW-1:0]  NoIndex         = '1;
  localparam logic [RoomW-1:0] HeaderRoomReset = RoomW'(6);

  typedef enum logic [StatW-1:0] {
    ST_INVALID   = 3'd0,
    ST_DUPLICATE = 3'd1,
    ST_PARTIAL   = 3'd2,
    ST_COMPLETE  = 3'd3,
    ST_MISSING   = 3'd4,
    ST_OVERFLOW  = 3'd5,
    ST_AUTH      = 3'd6
  } status_e;

  // Register indexes on the configuration port
  typedef enum logic {
    REG_DECRYPT_REQUIRED = 1'b0,
    REG_HEADER_ROOM      = 1'b1
  } reg_idx_e;

endpackage

@@ design/frt_hdr_if.sv @@
interface frt_hdr_if;
  logic       valid;
  logic       ready;
  logic [7:0] packet_index;
  logic [7:0] segment_index;
  logic [15:0] total_length;
  logic [7:0] key_byte;

  modport source (output valid, packet_index, segment_index, total_length, key_byte,
                  input ready);
  modport sink   (input valid, packet_index, segment_index, total_length, key_byte,
                  output ready);
endinterface

@@ design/frt_res_if.sv @@
interface frt_res_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [11:0] write_offset;
  logic [8:0]  write_length;
  logic        needs_decrypt;
  logic [31:0] frame_error_count;
  logic [31:0] auth_error_count;

  modport source (output valid, status, write_offset, write_length, needs_decrypt,
                  frame_error_count, auth_error_count,
                  input ready);
  modport sink   (input valid, status, write_offset, write_length, needs_decrypt,
                  frame_error_count, auth_error_count,
                  output ready);
endinterface

@@ design/frame_reassembly_tracker.sv @@
// Frame reassembly tracker: sequence check for packets split over frames.
// Channels: hdr_i carries one frame header per request (packet index,
// segment index, total length, key byte); res_o returns exactly one result
// per header (status, write offset/length, decrypt flag, error counters).
// The APB port sets decrypt_required (byte address 0) and header_room
// (byte address 4); write it only while no header is in flight.
// Throughput: one header per cycle while the result register is empty or
// being drained; the sequence state and the result register are both
// updated at the accepting edge, so the next header sees the new state
// at once.
// Stall: the result register holds while res_o.ready is low; hdr_i.ready
// is high whenever the result register is empty or being drained this
// cycle, so a stalled receiver stops intake only once its result waits.
// Reset: clears the sequence state (last indexes to 255, fill and MAC
// flag to 0), both error counters, the result valid flag, and loads the
// registers with decrypt_required = 0 and header_room = 6.
module frame_reassembly_tracker
  import frt_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  frt_hdr_if.sink           hdr_i,
  frt_res_if.source         res_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [PaddrW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  localparam logic [TotW:0] SegRound  = (TotW+1)'(SegmentBytes - 1);
  localparam logic [TotW:0] MaxTotal  = (TotW+1)'(SegmentBytes * MaxSegments);
  localparam logic [TotW:0] LimPlain  = (TotW+1)'(MaxHeaderBytes + BufferBytes);
  localparam logic [TotW:0] LimMac    = (TotW+1)'(MaxHeaderBytes + BufferBytes + MacBytes);
  localparam logic [TotW:0] MinTotal  = (TotW+1)'(MinPacketBytes);
  localparam logic [OffW:0] BufLimit  = (OffW+1)'(BufferBytes);
  localparam logic [OffW:0] MacRoom   = (OffW+1)'(MacBytes);
  localparam logic [LenW-1:0] FullLen = LenW'(SegmentBytes);

  // Configuration registers
  logic             decrypt_req_q;
  logic [RoomW-1:0] header_room_q;
  logic             cfg_wr;
  reg_idx_e         cfg_idx;

  // Sequence state
  logic [IdxW-1:0] last_pkt_q, last_pkt_d;
  logic [IdxW-1:0] last_seg_q, last_seg_d;
  logic [OffW-1:0] fill_q, fill_d;
  logic            mac_q, mac_d;
  logic [CntW-1:0] frame_err_q, frame_err_d;
  logic [CntW-1:0] auth_err_q, auth_err_d;

  // Result register
  logic            res_valid_q;
  status_e         status_q, status_d;
  logic [OffW-1:0] off_q, off_d;
  logic [LenW-1:0] len_q, len_d;
  logic            dec_q, dec_d;

  logic hdr_fire;

  // Decode work
  logic [TotW:0]   total_x;
  logic [TotW:0]   seg_round;
  logic [LenW-1:0] nseg;
  logic [LenW-1:0] seg_x;
  logic [LenW-1:0] seg_next;
  logic [TotW:0]   seg_base;
  logic [TotW:0]   seg_end;
  logic [TotW:0]   tail_len;
  logic            key_set;
  logic            bad_hdr;
  logic            is_dup;
  logic            is_gap;
  logic [LenW-1:0] cur_len;
  logic [OffW-1:0] fill_base;
  logic            mac_base;
  logic [OffW:0]   room;
  logic [OffW:0]   fill_sum;
  logic            is_last;

  // APB: always ready, decode on the word address bit
  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite;
  assign cfg_idx = reg_idx_e'(paddr[2]);

  always_comb begin
    unique case (cfg_idx)
      REG_DECRYPT_REQUIRED: prdata = {31'd0, decrypt_req_q};
      REG_HEADER_ROOM:      prdata = {{(32-RoomW){1'b0}}, header_room_q};
      default:              prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      decrypt_req_q <= 1'b0;
      header_room_q <= HeaderRoomReset;
    end else if (cfg_wr) begin
      if (cfg_idx == REG_DECRYPT_REQUIRED) begin
        decrypt_req_q <= pwdata[0];
      end else begin
        header_room_q <= pwdata[RoomW-1:0];
      end
    end
  end

  // Take a new request when the result slot is free or drains this cycle
  assign hdr_i.ready = ~res_valid_q | res_o.ready;
  assign hdr_fire    = hdr_i.valid & hdr_i.ready;

  // Header checks and segment length
  always_comb begin
    total_x   = {1'b0, hdr_i.total_length};
    seg_round = total_x + SegRound;
    nseg      = (total_x > MaxTotal) ? '0 : LenW'(seg_round >> SegShift);
    seg_x     = {1'b0, hdr_i.segment_index};
    key_set   = hdr_i.key_byte != '0;
    bad_hdr   = (total_x < MinTotal) || (total_x > (key_set ? LimMac : LimPlain)) ||
                (seg_x >= nseg);
    is_dup    = (last_pkt_q == hdr_i.packet_index) && (last_seg_q == hdr_i.segment_index);
    seg_next  = {1'b0, last_seg_q} + LenW'(1);
    is_gap    = (seg_next != seg_x) || (last_pkt_q != hdr_i.packet_index);
    seg_base  = (TotW+1)'(seg_x) << SegShift;
    seg_end   = seg_base + (TotW+1)'(SegmentBytes);
    tail_len  = total_x - seg_base;
    cur_len   = (seg_end > total_x) ? tail_len[LenW-1:0] : FullLen;
    is_last   = (seg_x + LenW'(1)) >= nseg;
  end

  // Sequence update and result selection
  always_comb begin
    last_pkt_d  = last_pkt_q;
    last_seg_d  = last_seg_q;
    fill_d      = fill_q;
    mac_d       = mac_q;
    frame_err_d = frame_err_q;
    auth_err_d  = auth_err_q;
    status_d    = ST_INVALID;
    off_d       = '0;
    len_d       = '0;
    dec_d       = 1'b0;

    // A start frame resets the fill before the overflow check
    fill_base = (seg_x == '0) ? '0 : fill_q;
    mac_base  = (seg_x == '0) ? key_set : mac_q;
    room      = (OffW+1)'(header_room_q) + (mac_base ? MacRoom : '0);
    fill_sum  = {1'b0, fill_base} + (OffW+1)'(cur_len);

    priority if (bad_hdr) begin
      status_d = ST_INVALID;
    end else if (is_dup) begin
      status_d = ST_DUPLICATE;
    end else if ((seg_x != '0) && is_gap) begin
      status_d    = ST_MISSING;
      frame_err_d = frame_err_q + CntW'(1);
    end else begin
      last_seg_d = hdr_i.segment_index;
      last_pkt_d = hdr_i.packet_index;
      fill_d     = fill_base;
      mac_d      = mac_base;
      if (fill_sum > BufLimit + room) begin
        status_d    = ST_OVERFLOW;
        frame_err_d = frame_err_q + CntW'(1);
      end else begin
        off_d  = fill_base;
        len_d  = cur_len;
        fill_d = fill_sum[OffW-1:0];
        if (!is_last) begin
          status_d = ST_PARTIAL;
        end else if (key_set) begin
          status_d = ST_COMPLETE;
          dec_d    = 1'b1;
          fill_d   = '0;
          mac_d    = 1'b0;
        end else if (decrypt_req_q) begin
          // Keep the fill until the next start frame
          status_d   = ST_AUTH;
          auth_err_d = auth_err_q + CntW'(1);
        end else begin
          status_d = ST_COMPLETE;
          fill_d   = '0;
          mac_d    = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_pkt_q  <= NoIndex;
      last_seg_q  <= NoIndex;
      fill_q      <= '0;
      mac_q       <= 1'b0;
      frame_err_q <= '0;
      auth_err_q  <= '0;
    end else if (hdr_fire) begin
      last_pkt_q  <= last_pkt_d;
      last_seg_q  <= last_seg_d;
      fill_q      <= fill_d;
      mac_q       <= mac_d;
      frame_err_q <= frame_err_d;
      auth_err_q  <= auth_err_d;
    end
  end

  // Result valid: set on intake, drop when taken without a new request
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (hdr_fire) begin
      res_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (hdr_fire) begin
      status_q <= status_d;
      off_q    <= off_d;
      len_q    <= len_d;
      dec_q    <= dec_d;
    end
  end

  assign res_o.valid             = res_valid_q;
  assign res_o.status            = status_q;
  assign res_o.write_offset      = off_q;
  assign res_o.write_length      = len_q;
  assign res_o.needs_decrypt     = dec_q;
  assign res_o.frame_error_count = frame_err_q;
  assign res_o.auth_error_count  = auth_err_q;

endmodule
